// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define AVST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also runs during reset
`define AVST_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/avst_pkg.sv -----
// shared types and constants of the affine vertex strip block
package avst_pkg;

  localparam int DW        = 32;
  localparam int FRAC      = 16;
  localparam int PROD_W    = 2 * DW;
  localparam int SUM_W     = PROD_W + 1;
  localparam int WIDE_W    = SUM_W - FRAC + 1;
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_M00    = 3'd0,
    REG_M01    = 3'd1,
    REG_M02    = 3'd2,
    REG_M10    = 3'd3,
    REG_M11    = 3'd4,
    REG_M12    = 3'd5,
    REG_FILL   = 3'd6,
    REG_STROKE = 3'd7
  } avst_reg_t;

  typedef enum logic [2:0] {
    K_FILL   = 3'd0,
    K_PASS   = 3'd1,
    K_PREV   = 3'd2,
    K_LATEST = 3'd3,
    K_TRIPLE = 3'd4
  } avst_kind_t;

  typedef struct packed {
    logic signed [DW-1:0] m00;
    logic signed [DW-1:0] m01;
    logic signed [DW-1:0] m02;
    logic signed [DW-1:0] m10;
    logic signed [DW-1:0] m11;
    logic signed [DW-1:0] m12;
    logic [DW-1:0]        fill_color;
    logic [DW-1:0]        stroke_color;
  } avst_cfg_t;

  typedef struct packed {
    avst_kind_t           kind;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
  } avst_entry_t;

endpackage

// ----- src/affine_vertex_strip_to_triangles.sv -----
// top level: affine vertex transform with stroke strip to triangle list conversion
//
//   channel  handshake             payload
//   in       in_valid / in_stall   req_type, first_vertex, x_in, y_in
//   out      out_valid / out_stall out_x, out_y, out_color, last
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// a taken vertex is registered after the multiply and again after the sum, then rounded into the queue
// the output register sends one result per cycle while out_stall is low: one per fill
// or early strip vertex, three per later strip vertex
// the eight-entry queue holds in-flight vertices; in_stall rises when it is committed
// synchronous reset clears strip state, pipeline, queue and output; cfg_ready stays high
module affine_vertex_strip_to_triangles import avst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic                 first_vertex,
  input  logic signed [DW-1:0] x_in,
  input  logic signed [DW-1:0] y_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] out_x,
  output logic signed [DW-1:0] out_y,
  output logic [DW-1:0]        out_color,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]        cfg_data
);

  avst_cfg_t         cfg;
  logic              push;
  avst_entry_t       push_data;
  logic              pop;
  avst_entry_t       head;
  logic              empty;
  logic [QCNT_W-1:0] q_count;

  avst_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  avst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .first_vertex (first_vertex),
    .x_in         (x_in),
    .y_in         (y_in),
    .cfg          (cfg),
    .q_count      (q_count),
    .push         (push),
    .push_data    (push_data)
  );

  avst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .count     (q_count)
  );

  avst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_color (out_color),
    .last      (last)
  );

endmodule

// ----- src/avst_regs.sv -----
// configuration register file: matrix coefficients and colors
module avst_regs import avst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]        cfg_data,
  output avst_cfg_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.m00          <= DW'(32'h0001_0000);
      cfg.m01          <= '0;
      cfg.m02          <= '0;
      cfg.m10          <= '0;
      cfg.m11          <= DW'(32'h0001_0000);
      cfg.m12          <= '0;
      cfg.fill_color   <= DW'(32'hFF00_0000);
      cfg.stroke_color <= DW'(32'hFF00_0000);
    end else if (cfg_valid && cfg_ready) begin
      case (avst_reg_t'(cfg_index))
        REG_M00:    cfg.m00          <= cfg_data;
        REG_M01:    cfg.m01          <= cfg_data;
        REG_M02:    cfg.m02          <= cfg_data;
        REG_M10:    cfg.m10          <= cfg_data;
        REG_M11:    cfg.m11          <= cfg_data;
        REG_M12:    cfg.m12          <= cfg_data;
        REG_FILL:   cfg.fill_color   <= cfg_data;
        REG_STROKE: cfg.stroke_color <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/avst_front.sv -----
// front end: accept, strip classification and affine transform pipeline
module avst_front import avst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic                 first_vertex,
  input  logic signed [DW-1:0] x_in,
  input  logic signed [DW-1:0] y_in,
  input  avst_cfg_t            cfg,
  input  logic [QCNT_W-1:0]    q_count,
  output logic                 push,
  output avst_entry_t          push_data
);

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [WIDE_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[WIDE_W-1:DW-1];
    hi_zeros = ~(|v[WIDE_W-1:DW-1]);
    if (hi_ones || hi_zeros) begin
      sat_dw = v[DW-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_dw = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_dw = {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  logic                     accept;
  logic [1:0]               strip_count;
  logic [1:0]               strip_count_next;
  logic [1:0]               cnt;
  avst_kind_t               kind;
  logic                     a_valid;
  logic                     b_valid;
  avst_kind_t               a_kind;
  avst_kind_t               b_kind;
  logic signed [PROD_W-1:0] p00;
  logic signed [PROD_W-1:0] p01;
  logic signed [PROD_W-1:0] p10;
  logic signed [PROD_W-1:0] p11;
  logic signed [SUM_W-1:0]  sx;
  logic signed [SUM_W-1:0]  sy;
  logic signed [WIDE_W-1:0] tx_w;
  logic signed [WIDE_W-1:0] ty_w;
  logic [QCNT_W:0]          occ;

  // queue slots in use plus those already promised to items in the pipeline
  assign occ = {1'b0, q_count} + (QCNT_W+1)'(a_valid) + (QCNT_W+1)'(b_valid);
  assign in_stall = occ >= (QCNT_W+1)'(QDEPTH);
  assign accept = in_valid && !in_stall;

  assign cnt = first_vertex ? 2'd0 : strip_count;
  assign strip_count_next = (cnt == 2'd3) ? 2'd3 : cnt + 2'd1;

  always_comb begin
    if (!req_type) begin
      kind = K_FILL;
    end else begin
      case (cnt)
        2'd0:    kind = K_PASS;
        2'd1:    kind = K_PREV;
        2'd2:    kind = K_LATEST;
        default: kind = K_TRIPLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_count <= '0;
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
    end else begin
      if (accept && req_type) begin
        strip_count <= strip_count_next;
      end
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind <= kind;
      p00    <= $signed(x_in) * $signed(cfg.m00);
      p01    <= $signed(y_in) * $signed(cfg.m01);
      p10    <= $signed(x_in) * $signed(cfg.m10);
      p11    <= $signed(y_in) * $signed(cfg.m11);
    end
    b_kind <= a_kind;
    sx     <= SUM_W'(p00) + SUM_W'(p01);
    sy     <= SUM_W'(p10) + SUM_W'(p11);
  end

  // floor division by 2^16, then translation
  assign tx_w = WIDE_W'($signed(sx[SUM_W-1:FRAC])) + WIDE_W'(cfg.m02);
  assign ty_w = WIDE_W'($signed(sy[SUM_W-1:FRAC])) + WIDE_W'(cfg.m12);

  assign push           = b_valid;
  assign push_data.kind = b_kind;
  assign push_data.x    = sat_dw(tx_w);
  assign push_data.y    = sat_dw(ty_w);

endmodule

// ----- src/avst_queue.sv -----
// queue of classified, transformed vertices between front and back
module avst_queue import avst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  avst_entry_t       push_data,
  input  logic              pop,
  output avst_entry_t       head,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  avst_entry_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/avst_back.sv -----
// back end: strip to list expansion and output register
module avst_back import avst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  avst_entry_t          head,
  input  logic                 empty,
  output logic                 pop,
  input  avst_cfg_t            cfg,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] out_x,
  output logic signed [DW-1:0] out_y,
  output logic [DW-1:0]        out_color,
  output logic                 last
);

  typedef enum logic [2:0] {
    PH_A = 3'b001,
    PH_B = 3'b010,
    PH_C = 3'b100
  } avst_phase_t;

  avst_phase_t          phase;
  avst_phase_t          phase_next;
  logic                 advance;
  logic                 fire;
  logic signed [DW-1:0] prev_x;
  logic signed [DW-1:0] prev_y;
  logic signed [DW-1:0] latest_x;
  logic signed [DW-1:0] latest_y;
  logic signed [DW-1:0] res_x;
  logic signed [DW-1:0] res_y;
  logic                 res_last;
  logic                 done;

  assign advance = !out_valid || !out_stall;
  assign fire    = advance && !empty;
  assign pop     = fire && done;

  always_comb begin
    res_x      = head.x;
    res_y      = head.y;
    res_last   = 1'b1;
    done       = 1'b1;
    phase_next = phase;
    if (head.kind == K_TRIPLE) begin
      case (phase)
        PH_B: begin
          res_x      = latest_x;
          res_y      = latest_y;
          res_last   = 1'b0;
          done       = 1'b0;
          phase_next = PH_C;
        end
        PH_C: begin
          phase_next = PH_A;
        end
        default: begin
          res_x      = prev_x;
          res_y      = prev_y;
          res_last   = 1'b0;
          done       = 1'b0;
          phase_next = PH_B;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_A;
      prev_x    <= '0;
      prev_y    <= '0;
      latest_x  <= '0;
      latest_y  <= '0;
    end else begin
      if (advance) begin
        out_valid <= !empty;
      end
      if (fire) begin
        phase <= phase_next;
        case (head.kind)
          K_PREV: begin
            prev_x <= head.x;
            prev_y <= head.y;
          end
          K_LATEST: begin
            latest_x <= head.x;
            latest_y <= head.y;
          end
          K_TRIPLE: begin
            if (done) begin
              prev_x   <= latest_x;
              prev_y   <= latest_y;
              latest_x <= head.x;
              latest_y <= head.y;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_x     <= res_x;
      out_y     <= res_y;
      out_color <= (head.kind == K_FILL) ? cfg.fill_color : cfg.stroke_color;
      last      <= res_last;
    end
  end

endmodule

// ----- src/avst_checker.sv -----
// port-level checker for the affine vertex strip block, bound to the top level
`include "assert_macros.svh"

module avst_checker import avst_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [DW-1:0] out_x,
  input logic signed [DW-1:0] out_y,
  input logic [DW-1:0]        out_color,
  input logic                 last
);

  // a stalled result keeps its payload
  `AVST_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_color) && $stable(last), "stalled result changed")

  // within a triangle, out_valid stays high after each non-last result is taken
  `AVST_ASSERT(a_triangle_burst, out_valid && !out_stall && !last |=> out_valid, "gap inside a triangle")

  // nothing is in flight right after reset
  `AVST_ASSERT_RST(a_reset_no_stall, !rst && $past(rst) |-> !in_stall, "input stalled after reset")

  `AVST_ASSERT_RST(a_reset_no_out, !rst && $past(rst) |-> !out_valid, "result shown after reset")

endmodule

bind affine_vertex_strip_to_triangles avst_checker u_avst_checker (.*);

// ----- tb/sv/affine_vertex_strip_to_triangles_tb.sv -----
// self-checking testbench for the affine vertex strip to triangle list block
`timescale 1ns / 1ps

module affine_vertex_strip_to_triangles_tb;
  import avst_pkg::*;

  localparam int          ACC_W        = 2 * DW + 2;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          SETTLE       = 16;
  localparam int          SUB_ITEMS    = 44;
  localparam logic        KIND_FILL    = 1'b0;
  localparam logic        KIND_STROKE  = 1'b1;
  localparam logic [DW-1:0] RESET_COLOR = 32'hFF000000;
  localparam logic [DW-1:0] ONE_Q16     = 32'h00010000;
  localparam logic signed [ACC_W-1:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_LO = -66'sd2147483648;

  typedef enum logic [1:0] {SET_RESET, SET_MAX, SET_MIN, SET_MIXED} setting_t;

  typedef struct packed {
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [DW-1:0] color;
    logic          last;
  } result_item_t;

  typedef struct packed {
    setting_t      setting;
    logic          kind;
    logic          first;
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic          typed;
    logic [DW-1:0] ex;
    logic [DW-1:0] ey;
    logic [DW-1:0] ecolor;
  } vertex_row_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 req_type     = 1'b0;
  logic                 first_vertex = 1'b0;
  logic signed [DW-1:0] x_in         = '0;
  logic signed [DW-1:0] y_in         = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic signed [DW-1:0] out_x;
  logic signed [DW-1:0] out_y;
  logic [DW-1:0]        out_color;
  logic                 last;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [DW-1:0]        cfg_data     = '0;

  logic [DW-1:0] regs_model [8];
  logic [DW-1:0] next_regs  [8];
  logic [1:0]    strip_len;
  logic [DW-1:0] older_x, older_y, newer_x, newer_y;

  result_item_t expected_vertices [$];
  vertex_row_t  directed_rows [$];
  result_item_t head;
  int          errors       = 0;
  int          cycle_count  = 0;
  int          send_idle_pct = 25;
  int          stall_pct     = 85;

  affine_vertex_strip_to_triangles i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .first_vertex (first_vertex),
    .x_in         (x_in),
    .y_in         (y_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_color    (out_color),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        $display("%0t unexpected transaction x=%h y=%h color=%h last=%b",
                 $time, out_x, out_y, out_color, last);
        errors = errors + 1;
      end else begin
        head = expected_vertices.pop_front();
        if (out_x !== head.x) begin
          $display("%0t out_x expected %h actual %h", $time, head.x, out_x);
          errors = errors + 1;
        end
        if (out_y !== head.y) begin
          $display("%0t out_y expected %h actual %h", $time, head.y, out_y);
          errors = errors + 1;
        end
        if (out_color !== head.color) begin
          $display("%0t out_color expected %h actual %h", $time, head.color, out_color);
          errors = errors + 1;
        end
        if (last !== head.last) begin
          $display("%0t last expected %b actual %b", $time, head.last, last);
          errors = errors + 1;
        end
      end
    end
  end

  function automatic logic [DW-1:0] affine_row(input logic [DW-1:0] ca, cb, ct, xv, yv);
    logic signed [ACC_W-1:0] acc;
    acc = $signed({{(ACC_W-DW){ca[DW-1]}}, ca} * {{(ACC_W-DW){xv[DW-1]}}, xv})
        + $signed({{(ACC_W-DW){cb[DW-1]}}, cb} * {{(ACC_W-DW){yv[DW-1]}}, yv});
    acc = acc >>> FRAC;
    acc = acc + $signed({{(ACC_W-DW){ct[DW-1]}}, ct});
    if (acc > SAT_HI) return SAT_HI[DW-1:0];
    if (acc < SAT_LO) return SAT_LO[DW-1:0];
    return acc[DW-1:0];
  endfunction

  task automatic queue_result(input logic [DW-1:0] rx, ry, rc, input logic rl);
    expected_vertices.insert(expected_vertices.size(), '{rx, ry, rc, rl});
  endtask

  task automatic predict_vertex(input logic kind, input logic fv,
                                input logic [DW-1:0] xv, input logic [DW-1:0] yv);
    logic [DW-1:0] tx, ty, sc;
    tx = affine_row(regs_model[REG_M00], regs_model[REG_M01], regs_model[REG_M02], xv, yv);
    ty = affine_row(regs_model[REG_M10], regs_model[REG_M11], regs_model[REG_M12], xv, yv);
    sc = regs_model[REG_STROKE];
    if (kind == KIND_FILL) begin
      queue_result(tx, ty, regs_model[REG_FILL], 1'b1);
    end else begin
      if (fv) strip_len = 2'd0;
      case (strip_len)
        2'd0: begin
          queue_result(tx, ty, sc, 1'b1);
          strip_len = 2'd1;
        end
        2'd1: begin
          older_x = tx;
          older_y = ty;
          queue_result(tx, ty, sc, 1'b1);
          strip_len = 2'd2;
        end
        2'd2: begin
          newer_x = tx;
          newer_y = ty;
          queue_result(tx, ty, sc, 1'b1);
          strip_len = 2'd3;
        end
        default: begin
          queue_result(older_x, older_y, sc, 1'b0);
          queue_result(newer_x, newer_y, sc, 1'b0);
          queue_result(tx, ty, sc, 1'b1);
          older_x = newer_x;
          older_y = newer_y;
          newer_x = tx;
          newer_y = ty;
        end
      endcase
    end
  endtask

  task automatic send_vertex(input logic kind, input logic fv,
                             input logic [DW-1:0] xv, input logic [DW-1:0] yv);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    first_vertex <= fv;
    x_in         <= xv;
    y_in         <= yv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_vertex(kind, fv, xv, yv);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs();
    for (int i = REG_M00; i <= REG_STROKE; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= next_regs[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      regs_model[i] = next_regs[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic choose_setting(input setting_t s);
    case (s)
      SET_MAX: begin
        for (int i = REG_M00; i <= REG_M12; i++) next_regs[i] = 32'h7FFFFFFF;
        next_regs[REG_FILL]   = 32'hFFFFFFFF;
        next_regs[REG_STROKE] = 32'h00000000;
      end
      SET_MIN: begin
        for (int i = REG_M00; i <= REG_M12; i++) next_regs[i] = 32'h80000000;
        next_regs[REG_FILL]   = 32'h00000000;
        next_regs[REG_STROKE] = 32'hFFFFFFFF;
      end
      default: begin
        next_regs[REG_M00]    = 32'h00008000;
        next_regs[REG_M01]    = 32'hFFFF0000;
        next_regs[REG_M02]    = 32'h7FFF0000;
        next_regs[REG_M10]    = 32'h00030000;
        next_regs[REG_M11]    = 32'hFFFF8000;
        next_regs[REG_M12]    = 32'h80000000;
        next_regs[REG_FILL]   = 32'h11223344;
        next_regs[REG_STROKE] = 32'hAABBCCDD;
      end
    endcase
  endtask

  function automatic logic [DW-1:0] pick_extreme();
    case ($urandom_range(3, 0))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return 32'h00000000;
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_coord();
    case ($urandom_range(3, 0))
      0:       return $urandom_range(32'h00FFFFFF, 0) - 32'h00800000;
      1:       return pick_extreme();
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_coef();
    case ($urandom_range(4, 0))
      0:       return $urandom;
      1:       return pick_extreme();
      default: return $urandom_range(32'h0007FFFF, 0) - 32'h00040000;
    endcase
  endfunction

  task automatic add_row(input setting_t s, input logic kind, input logic fv,
                         input logic [DW-1:0] xv, input logic [DW-1:0] yv, input logic typed,
                         input logic [DW-1:0] ex, input logic [DW-1:0] ey,
                         input logic [DW-1:0] ec);
    directed_rows.insert(directed_rows.size(), '{s, kind, fv, xv, yv, typed, ex, ey, ec});
  endtask

  initial begin
    vertex_row_t row;
    setting_t    cur_setting;
    int          sent;
    int          path_len;
    int          pick;
    logic        kind;
    logic        fv;

    regs_model[REG_M00]    = ONE_Q16;
    regs_model[REG_M01]    = '0;
    regs_model[REG_M02]    = '0;
    regs_model[REG_M10]    = '0;
    regs_model[REG_M11]    = ONE_Q16;
    regs_model[REG_M12]    = '0;
    regs_model[REG_FILL]   = RESET_COLOR;
    regs_model[REG_STROKE] = RESET_COLOR;
    strip_len = 2'd0;
    older_x = '0;
    older_y = '0;
    newer_x = '0;
    newer_y = '0;

    // identity matrix after reset
    add_row(SET_RESET, KIND_FILL, 1'b0, 32'h7FFFFFFF, 32'h80000000, 1'b1,
            32'h7FFFFFFF, 32'h80000000, RESET_COLOR);
    add_row(SET_RESET, KIND_STROKE, 1'b0, 32'h00000001, 32'h00000002, 1'b1,
            32'h00000001, 32'h00000002, RESET_COLOR);
    add_row(SET_RESET, KIND_STROKE, 1'b0, 32'hFFFFFFFF, 32'h12345678, 1'b1,
            32'hFFFFFFFF, 32'h12345678, RESET_COLOR);
    add_row(SET_RESET, KIND_FILL, 1'b1, 32'h80000000, 32'h7FFFFFFF, 1'b1,
            32'h80000000, 32'h7FFFFFFF, RESET_COLOR);
    add_row(SET_RESET, KIND_STROKE, 1'b0, 32'h00000005, 32'h00000006, 1'b1,
            32'h00000005, 32'h00000006, RESET_COLOR);
    add_row(SET_RESET, KIND_STROKE, 1'b0, 32'h00000007, 32'h00000008, 1'b0, '0, '0, '0);
    add_row(SET_RESET, KIND_STROKE, 1'b0, 32'h00000009, 32'h0000000A, 1'b0, '0, '0, '0);
    add_row(SET_RESET, KIND_FILL, 1'b0, 32'h00000000, 32'h00000000, 1'b1,
            32'h00000000, 32'h00000000, RESET_COLOR);
    add_row(SET_RESET, KIND_STROKE, 1'b0, 32'h0000000B, 32'h0000000C, 1'b0, '0, '0, '0);
    add_row(SET_RESET, KIND_STROKE, 1'b1, 32'h0000000D, 32'h0000000E, 1'b1,
            32'h0000000D, 32'h0000000E, RESET_COLOR);
    add_row(SET_RESET, KIND_STROKE, 1'b0, 32'h0000000F, 32'h00000010, 1'b1,
            32'h0000000F, 32'h00000010, RESET_COLOR);
    add_row(SET_RESET, KIND_STROKE, 1'b0, 32'h00000011, 32'h00000012, 1'b1,
            32'h00000011, 32'h00000012, RESET_COLOR);
    add_row(SET_RESET, KIND_STROKE, 1'b0, 32'h00000013, 32'h00000014, 1'b0, '0, '0, '0);
    // saturation at the coefficient extremes, then a mixed setting
    add_row(SET_MAX, KIND_FILL, 1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    add_row(SET_MAX, KIND_FILL, 1'b0, 32'h80000000, 32'h80000000, 1'b1,
            32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    add_row(SET_MAX, KIND_STROKE, 1'b1, 32'h00000000, 32'h00000000, 1'b1,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000000);
    add_row(SET_MIN, KIND_FILL, 1'b0, 32'h80000000, 32'h80000000, 1'b1,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000000);
    add_row(SET_MIN, KIND_FILL, 1'b0, 32'h00000000, 32'h00000000, 1'b1,
            32'h80000000, 32'h80000000, 32'h00000000);
    add_row(SET_MIN, KIND_STROKE, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1,
            32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    add_row(SET_MIXED, KIND_STROKE, 1'b1, 32'h00010000, 32'hFFFF0000, 1'b0, '0, '0, '0);
    add_row(SET_MIXED, KIND_STROKE, 1'b0, 32'h80000000, 32'h7FFFFFFF, 1'b0, '0, '0, '0);
    add_row(SET_MIXED, KIND_STROKE, 1'b0, 32'h12345678, 32'h9ABCDEF0, 1'b0, '0, '0, '0);
    add_row(SET_MIXED, KIND_STROKE, 1'b0, 32'hFFFFFFFF, 32'h00000001, 1'b0, '0, '0, '0);
    add_row(SET_MIXED, KIND_FILL, 1'b0, 32'h00000001, 32'hFFFFFFFF, 1'b0, '0, '0, '0);
    add_row(SET_MIXED, KIND_STROKE, 1'b0, 32'h7FFFFFFF, 32'h80000000, 1'b0, '0, '0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 25;
    stall_pct     = 85;
    cur_setting   = SET_RESET;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.setting != cur_setting) begin
        wait_idle();
        choose_setting(row.setting);
        program_regs();
        cur_setting = row.setting;
      end
      send_vertex(row.kind, row.first, row.x, row.y);
      if (row.typed)
        expected_vertices[expected_vertices.size()-1] = '{row.ex, row.ey, row.ecolor, 1'b1};
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 25;
          stall_pct     = 85;
        end
        1: begin
          send_idle_pct = 85;
          stall_pct     = 25;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        wait_idle();
        for (int i = REG_M00; i <= REG_M12; i++) next_regs[i] = rand_coef();
        next_regs[REG_FILL]   = $urandom;
        next_regs[REG_STROKE] = $urandom;
        program_regs();
        sent = 0;
        while (sent < SUB_ITEMS) begin
          path_len = $urandom_range(9, 1);
          for (int k = 0; k < path_len; k++) begin
            pick = $urandom_range(99, 0);
            if (pick < 10) begin
              kind = KIND_FILL;
              fv   = $urandom_range(1, 0);
            end else if (pick < 18) begin
              kind = KIND_STROKE;
              fv   = $urandom_range(1, 0);
            end else begin
              kind = KIND_STROKE;
              fv   = (k == 0);
            end
            send_vertex(kind, fv, rand_coord(), rand_coord());
            sent++;
          end
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
